[sv/rccf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rccf_pkg
// Types, constants and command/status structs shared by the consensus filter.
// ---------------------------------------------------------------------------
package rccf_pkg;

    localparam int GROUP_COUNT = 12;
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    localparam logic [2:0] V_PUBLISH   = 3'd0;
    localparam logic [2:0] V_NO_FRAME  = 3'd1;
    localparam logic [2:0] V_DEC_ERROR = 3'd2;
    localparam logic [2:0] V_LOW_CONF  = 3'd3;
    localparam logic [2:0] V_UNSTABLE  = 3'd4;
    localparam logic [2:0] V_DUPLICATE = 3'd5;
    localparam logic [2:0] CLS_ALL     = 3'd6;
    localparam logic [2:0] CLS_OK      = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFRAME = 2'd1;
    localparam logic [1:0] ST_DECERR  = 2'd2;
    localparam logic [1:0] ST_UNUSED  = 2'd3;

    localparam logic [2:0] REG_REPEAT = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_NEAR   = 3'd2;
    localparam logic [2:0] REG_MINCONF = 3'd3;
    localparam logic [2:0] REG_GAP    = 3'd4;

    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  decode_status;
        logic [23:0] decoded_code;
        logic [15:0] frame_confidence;
        logic [31:0] driver_sequence;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [23:0] event_code;
        logic [15:0] event_confidence;
        logic [31:0] frame_number;
        logic [31:0] verdict_count;
        logic [31:0] driver_drop_total;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          load;     // capture input, update sequence and counters
        logic          scan;     // examine group at index
        logic          commit;   // apply group decision and finish verdict
        logic          finish;   // bump verdict counter, fill output
        logic [GW-1:0] idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_groups;  // item goes through the group table
    } dp_sts_t;

endpackage

[sv/rccf_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rccf_datapath
// Registers, group table and counters; steps driven by the controller.
// ---------------------------------------------------------------------------
module rccf_datapath
    import rccf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  in_item_t  item,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output out_item_t result
);

    logic [15:0] repeat_reg, window_reg, minconf_reg, gap_reg;
    logic [3:0]  near_reg;

    logic [GROUP_COUNT-1:0] act_reg;
    logic [23:0] anchor_reg [GROUP_COUNT];
    logic [23:0] bcode_reg  [GROUP_COUNT];
    logic [15:0] bconf_reg  [GROUP_COUNT];
    logic [15:0] hits_reg   [GROUP_COUNT];
    logic [31:0] last_reg   [GROUP_COUNT];

    logic [31:0] frame_reg, lpub_frame_reg, prev_seq_reg, missed_reg;
    logic [23:0] lpub_code_reg;
    logic        have_pub_reg, have_seq_reg;
    logic [31:0] cls_reg [8];

    in_item_t    it_reg;
    logic [2:0]  verdict_reg;
    logic        grp_reg;
    // Scan results.
    logic          found_reg, free_reg;
    logic [4:0]    bestd_reg;
    logic [GW-1:0] fidx_reg, freeidx_reg, lruidx_reg;
    logic [31:0]   lru_reg;

    logic [31:0] window_eff;
    logic [3:0]  limit_eff;
    logic [4:0]  hdist;
    logic        expired, live;
    logic [GW-1:0] i;

    assign window_eff = (window_reg == 16'd0) ? 32'd12 : {16'd0, window_reg};
    assign limit_eff  = (near_reg > 4'd12) ? 4'd12 : near_reg;
    assign i = cmd.idx;
    assign expired = act_reg[i] && ((frame_reg - last_reg[i]) > window_eff);
    assign live = act_reg[i] && !expired;
    assign hdist = 5'($countones(it_reg.decoded_code ^ anchor_reg[i]));
    assign sts.need_groups = grp_reg;

    logic [15:0] hits_inc;
    logic        take_best;
    logic [15:0] conf_c;
    logic [23:0] code_c;
    logic [15:0] evconf_c;
    logic [GW-1:0] pick;
    logic [2:0]  v_c;
    logic        dup;

    always_comb
    begin
        hits_inc  = (hits_reg[fidx_reg] < 16'hFFFF) ? hits_reg[fidx_reg] + 16'd1
                                                    : hits_reg[fidx_reg];
        take_best = it_reg.frame_confidence >= bconf_reg[fidx_reg];
        conf_c    = take_best ? it_reg.frame_confidence : bconf_reg[fidx_reg];
        code_c    = take_best ? it_reg.decoded_code : bcode_reg[fidx_reg];
        evconf_c  = (conf_c > it_reg.frame_confidence) ? conf_c : it_reg.frame_confidence;
        pick      = free_reg ? freeidx_reg : lruidx_reg;
        if (grp_reg && found_reg)
        begin
            v_c = ({16'd0, hits_inc} < {16'd0, repeat_reg}) ? V_UNSTABLE : V_PUBLISH;
        end
        else if (grp_reg)
        begin
            v_c = V_UNSTABLE;
        end
        else
        begin
            v_c = V_PUBLISH;
        end
        if (!grp_reg)
        begin
            code_c   = it_reg.decoded_code;
            evconf_c = it_reg.frame_confidence;
        end
        dup = have_pub_reg && (code_c == lpub_code_reg)
              && ((frame_reg - lpub_frame_reg) < {16'd0, gap_reg});
    end

    logic [32:0] gap_sum;
    logic [31:0] gap_w;
    assign gap_w   = item.driver_sequence - prev_seq_reg - 32'd1;
    assign gap_sum = {1'b0, missed_reg} + {1'b0, gap_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_reg <= 16'd2; window_reg <= 16'd12; near_reg <= 4'd4;
            minconf_reg <= 16'd47186; gap_reg <= 16'd6;
            act_reg <= '0;
            frame_reg <= '0; lpub_frame_reg <= '0; prev_seq_reg <= '0;
            missed_reg <= '0; lpub_code_reg <= '0;
            have_pub_reg <= 1'b0; have_seq_reg <= 1'b0;
            for (int k = 0; k < 8; k++) cls_reg[k] <= '0;
            for (int k = 0; k < GROUP_COUNT; k++) last_reg[k] <= '0;
            grp_reg <= 1'b0;
            verdict_reg <= V_PUBLISH;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_REPEAT:  repeat_reg  <= cfg_data;
                    REG_WINDOW:  window_reg  <= cfg_data;
                    REG_NEAR:    near_reg    <= cfg_data[3:0];
                    REG_MINCONF: minconf_reg <= cfg_data;
                    REG_GAP:     gap_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                it_reg <= item;
                if (have_seq_reg && item.driver_sequence > prev_seq_reg)
                    missed_reg <= gap_sum[32] ? U32_MAX : gap_sum[31:0];
                prev_seq_reg <= item.driver_sequence;
                have_seq_reg <= 1'b1;
                if (cls_reg[CLS_ALL] != U32_MAX) cls_reg[CLS_ALL] <= cls_reg[CLS_ALL] + 32'd1;
                frame_reg <= frame_reg + 32'd1;
                grp_reg <= 1'b0;
                if (item.decode_status != ST_OK)
                begin
                    verdict_reg <= (item.decode_status == ST_NOFRAME) ? V_NO_FRAME
                                                                     : V_DEC_ERROR;
                end
                else
                begin
                    if (cls_reg[CLS_OK] != U32_MAX) cls_reg[CLS_OK] <= cls_reg[CLS_OK] + 32'd1;
                    if (item.frame_confidence < minconf_reg)
                        verdict_reg <= V_LOW_CONF;
                    else
                    begin
                        verdict_reg <= V_PUBLISH;
                        grp_reg <= repeat_reg > 16'd1;
                    end
                end
                found_reg <= 1'b0; free_reg <= 1'b0;
                bestd_reg <= '0; fidx_reg <= '0; freeidx_reg <= '0;
                lruidx_reg <= '0; lru_reg <= '0;
            end
            if (cmd.scan)
            begin
                // One group per cycle: expire, then match, free and oldest search.
                if (expired)
                begin
                    act_reg[i] <= 1'b0;
                    last_reg[i] <= '0;
                end
                if (live && (hdist <= {1'b0, limit_eff}) && (!found_reg || hdist < bestd_reg))
                begin
                    found_reg <= 1'b1; bestd_reg <= hdist; fidx_reg <= i;
                end
                if (!live && !free_reg)
                begin
                    free_reg <= 1'b1; freeidx_reg <= i;
                end
                if (i == '0 || last_reg[i] < lru_reg)
                begin
                    lruidx_reg <= i; lru_reg <= last_reg[i];
                end
            end
            if (cmd.commit)
            begin
                if (grp_reg && !found_reg)
                begin
                    act_reg[pick] <= 1'b1;
                    last_reg[pick] <= frame_reg;
                end
                else if (grp_reg)
                    last_reg[fidx_reg] <= frame_reg;
                if (verdict_reg == V_PUBLISH)
                begin
                    if (v_c == V_PUBLISH && dup)
                        verdict_reg <= V_DUPLICATE;
                    else if (v_c == V_PUBLISH)
                    begin
                        lpub_code_reg <= code_c;
                        lpub_frame_reg <= frame_reg;
                        have_pub_reg <= 1'b1;
                        verdict_reg <= V_PUBLISH;
                    end
                    else
                        verdict_reg <= v_c;
                end
            end
            if (cmd.finish && cls_reg[verdict_reg] != U32_MAX)
                cls_reg[verdict_reg] <= cls_reg[verdict_reg] + 32'd1;
        end
    end

    // Group payload fields; validity is carried by act_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && grp_reg && !found_reg)
        begin
            anchor_reg[pick] <= it_reg.decoded_code;
            bcode_reg[pick]  <= it_reg.decoded_code;
            bconf_reg[pick]  <= it_reg.frame_confidence;
            hits_reg[pick]   <= 16'd1;
        end
        else if (cmd.commit && grp_reg)
        begin
            hits_reg[fidx_reg]  <= hits_inc;
            bcode_reg[fidx_reg] <= code_c;
            bconf_reg[fidx_reg] <= conf_c;
        end
        if (cmd.commit)
        begin
            result.event_code <= code_c;
            result.event_confidence <= evconf_c;
        end
        if (cmd.finish)
        begin
            result.verdict <= verdict_reg;
            if (verdict_reg != V_PUBLISH)
            begin
                result.event_code <= '0;
                result.event_confidence <= '0;
            end
            result.frame_number <= frame_reg;
            result.verdict_count <= (cls_reg[verdict_reg] != U32_MAX)
                                    ? cls_reg[verdict_reg] + 32'd1 : U32_MAX;
            result.driver_drop_total <= missed_reg;
        end
    end

endmodule

[sv/rccf_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rccf_ctrl
// Sequencer: load, group scan if needed, commit, finish, hold the result.
// ---------------------------------------------------------------------------
module rccf_ctrl
    import rccf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_COMMIT, S_FINISH, S_OUT} state_t;

    state_t        state_reg;
    logic [GW-1:0] idx_reg;

    // Input is taken in idle, or while the previous result is on offer unstalled.
    assign in_stall  = !(state_reg == S_IDLE || (state_reg == S_OUT && !out_stall));
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.load   = in_valid && !in_stall;
        cmd.scan   = state_reg == S_SCAN;
        cmd.commit = state_reg == S_COMMIT;
        cmd.finish = state_reg == S_FINISH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_LOAD;
                S_LOAD:
                begin
                    idx_reg <= '0;
                    state_reg <= sts.need_groups ? S_SCAN : S_COMMIT;
                end
                S_SCAN:
                begin
                    if (idx_reg == GW'(GROUP_COUNT - 1)) state_reg <= S_COMMIT;
                    else idx_reg <= idx_reg + GW'(1);
                end
                S_COMMIT: state_reg <= S_FINISH;
                S_FINISH: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!out_stall) state_reg <= in_valid ? S_LOAD : S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/rf_code_consensus_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rf_code_consensus_filter
// Flags failed, weak and repeated frames; publishes codes agreed by groups.
// ---------------------------------------------------------------------------
// After accept the controller steps through load, an optional group scan,
// commit and finish; one group entry is examined per scan cycle.
// A new request is taken only in idle or as the previous result is handed off.
// Reset clears counters and group valid bits; config registers get defaults.
module rf_code_consensus_filter
    import rccf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rccf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    rccf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item(in_item), .cmd(cmd), .sts(sts), .result(out_item)
    );

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> in_stall) else $error("input taken during group scan");
    a_commit_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> ##1 out_valid) else $error("result not presented after commit");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");
`endif

endmodule
